FILE: src/bincnt_pkg.sv
package bincnt_pkg;

	localparam int COL_W     = 6;
	localparam int ROW_W     = 11;
	localparam int CFG_W     = 11;
	localparam int REG_IDX_W = 1;
	localparam int CNT_W     = 4;

	localparam logic [ROW_W-1:0] MAX_ROWS = 11'd1024;

	localparam logic [COL_W-1:0] FRAME_COLS_RST = 6'd32;
	localparam logic [ROW_W-1:0] FRAME_ROWS_RST = 11'd32;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

	typedef struct packed {
		logic fire;
		logic has_left;
		logic emit_mid;
		logic emit_end;
		logic last;
	} step_ctl_t;

	typedef struct packed {
		logic             is_set;
		logic [CNT_W-1:0] count;
		logic             last;
	} res_t;

endpackage

FILE: src/bincnt_cell.sv
module bincnt_cell (
	input  logic clk,
	input  logic shift,
	input  logic l1_in,
	input  logic l2_in,
	output logic l1,
	output logic l2
);

	logic l1_q;
	logic l2_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			l1_q <= l1_in;
			l2_q <= l2_in;
		end
	end

	assign l1 = l1_q;
	assign l2 = l2_q;

endmodule

FILE: src/bincnt_window.sv
module bincnt_window import bincnt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_ctl_t ctl,
	input  logic [2:0] ncol,
	output logic      push_a,
	output logic      push_b,
	output res_t      res_a,
	output res_t      res_b
);

	// columns c-2 and c-1; bit 2 top row, bit 0 bottom row
	logic [2:0] left_q;
	logic [2:0] mid_q;
	logic [2:0] left_m;

	function automatic logic [CNT_W-1:0] ones3(input logic [2:0] v);
		ones3 = CNT_W'(v[0]) + CNT_W'(v[1]) + CNT_W'(v[2]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			mid_q  <= '0;
		end else if (ctl.fire) begin
			left_q <= mid_q;
			mid_q  <= ncol;
		end
	end

	assign left_m = ctl.has_left ? left_q : 3'b000;

	always_comb begin
		res_a.is_set = mid_q[1];
		res_a.count  = mid_q[1] ? '0 :
			ones3(left_m) + ones3({mid_q[2], 1'b0, mid_q[0]}) + ones3(ncol);
		res_a.last   = 1'b0;

		res_b.is_set = ncol[1];
		res_b.count  = ncol[1] ? '0 : ones3(mid_q) + ones3({ncol[2], 1'b0, ncol[0]});
		res_b.last   = ctl.last;
	end

	assign push_a = ctl.fire && ctl.emit_mid;
	assign push_b = ctl.fire && ctl.emit_end;

endmodule

FILE: src/bincnt_outq.sv
module bincnt_outq import bincnt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_a,
	input  logic push_b,
	input  res_t res_a,
	input  res_t res_b,
	input  logic out_stall,
	output logic out_valid,
	output res_t head,
	output logic nearly_full
);

	logic [1:0] cnt_q;
	logic [1:0] cnt_d;
	logic [1:0] base;
	logic       pop;
	res_t       q_q [3];
	res_t       q_d [3];

	assign out_valid   = cnt_q != 2'd0;
	assign pop         = out_valid && !out_stall;
	assign base        = cnt_q - {1'b0, pop};
	assign cnt_d       = base + {1'b0, push_a} + {1'b0, push_b};
	assign nearly_full = cnt_q[1];
	assign head        = q_q[0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_d[i] = q_q[i];
			if (pop && i < 2)
				q_d[i] = q_q[i+1];
			if (push_a && base == 2'(i))
				q_d[i] = res_a;
			if (push_b && (base + {1'b0, push_a}) == 2'(i))
				q_d[i] = res_b;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			q_q[i] <= q_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

endmodule

FILE: src/binary_image_neighbor_count.sv
// Binary image 3x3 neighbour counter. Pixels enter in raster order, one per clock while
// in_stall is low; each pixel yields one result in raster order, either its own set flag
// or the count of set neighbours (pixels outside the frame count as zero). The frame size
// is taken from frame_cols and frame_rows when the first pixel of a frame is accepted and
// is saturated to 2..MAX_COLS and 2..1024. Results leave through a three-entry queue, one
// per clock while out_stall is low; the last pixel of every row but the first yields two
// results, and after the last pixel of a frame input is held while the chain of column
// cells is flushed to deliver the bottom row, whose final result carries frame_last.
// The line delay lives in a chain of MAX_COLS cells, each holding two bits.
module binary_image_neighbor_count import bincnt_pkg::*; #(
	parameter int MAX_COLS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pixel_bit,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_set,
	output logic [CNT_W-1:0]     neighbor_count,
	output logic                 frame_last
);

	localparam int IDX_W = $clog2(MAX_COLS);
	localparam logic [COL_W-1:0] MAX_COLS_V = COL_W'(MAX_COLS);

	logic [COL_W-1:0] frame_cols_q;
	logic [ROW_W-1:0] frame_rows_q;
	logic [COL_W-1:0] act_cols_q;
	logic [ROW_W-1:0] act_rows_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             draining_q;

	logic [COL_W-1:0] sat_cols;
	logic [ROW_W-1:0] sat_rows;
	logic [COL_W-1:0] cols_use;
	logic [ROW_W-1:0] rows_use;
	logic             first;
	logic             last_col;
	logic             step;
	logic             pix;
	logic [IDX_W-1:0] tap_idx;
	logic             tap1;
	logic             tap2;
	logic [2:0]       ncol;
	logic             nearly_full;

	logic [MAX_COLS-1:0] l1;
	logic [MAX_COLS-1:0] l2;

	step_ctl_t ctl;
	logic      push_a;
	logic      push_b;
	res_t      res_a;
	res_t      res_b;
	res_t      head;

	assign sat_cols = (frame_cols_q < 6'd2) ? 6'd2 :
		((frame_cols_q > MAX_COLS_V) ? MAX_COLS_V : frame_cols_q);
	assign sat_rows = (frame_rows_q < 11'd2) ? 11'd2 :
		((frame_rows_q > MAX_ROWS) ? MAX_ROWS : frame_rows_q);

	assign first    = !draining_q && row_q == '0 && col_q == '0;
	assign cols_use = first ? sat_cols : act_cols_q;
	assign rows_use = first ? sat_rows : act_rows_q;
	assign last_col = col_q == (cols_use - 6'd1);

	assign in_stall = draining_q || nearly_full;
	assign step     = (in_valid && !in_stall) || (draining_q && !nearly_full);
	assign pix      = !draining_q && pixel_bit;

	// line delay taps
	assign tap_idx = IDX_W'(cols_use - 6'd1);
	assign tap1    = l1[tap_idx];
	assign tap2    = l2[tap_idx];
	assign ncol    = {tap2 && (row_q >= 11'd2), tap1 && (row_q != '0), pix};

	genvar k;
	generate
		for (k = 0; k < MAX_COLS; k++) begin : g_cell
			if (k == 0) begin : g_head
				bincnt_cell u_cell (
					.clk   (clk),
					.shift (step),
					.l1_in (pix),
					.l2_in (tap1),
					.l1    (l1[k]),
					.l2    (l2[k])
				);
			end else begin : g_body
				bincnt_cell u_cell (
					.clk   (clk),
					.shift (step),
					.l1_in (l1[k-1]),
					.l2_in (l2[k-1]),
					.l1    (l1[k]),
					.l2    (l2[k])
				);
			end
		end
	endgenerate

	always_comb begin
		ctl.fire     = step;
		ctl.has_left = col_q >= 6'd2;
		ctl.emit_mid = row_q != '0 && col_q != '0;
		ctl.emit_end = row_q != '0 && last_col;
		ctl.last     = draining_q && last_col;
	end

	bincnt_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.ncol   (ncol),
		.push_a (push_a),
		.push_b (push_b),
		.res_a  (res_a),
		.res_b  (res_b)
	);

	bincnt_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_a      (push_a),
		.push_b      (push_b),
		.res_a       (res_a),
		.res_b       (res_b),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.head        (head),
		.nearly_full (nearly_full)
	);

	assign is_set         = head.is_set;
	assign neighbor_count = head.count;
	assign frame_last     = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= FRAME_COLS_RST;
			frame_rows_q <= FRAME_ROWS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_COLS: frame_cols_q <= cfg_data[COL_W-1:0];
				REG_FRAME_ROWS: frame_rows_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cols_q <= FRAME_COLS_RST;
			act_rows_q <= FRAME_ROWS_RST;
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (step) begin
			if (first) begin
				act_cols_q <= sat_cols;
				act_rows_q <= sat_rows;
			end
			if (last_col) begin
				col_q <= '0;
				if (draining_q) begin
					draining_q <= 1'b0;
					row_q      <= '0;
				end else begin
					if (row_q == rows_use - 11'd1)
						draining_q <= 1'b1;
					row_q <= row_q + 11'd1;
				end
			end else begin
				col_q <= col_q + 6'd1;
			end
		end
	end

endmodule

FILE: src/bincnt_checker.sv
module bincnt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       is_set,
	input logic [3:0] neighbor_count,
	input logic       frame_last
);

	// a stalled request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_set) &&
			$stable(neighbor_count) && $stable(frame_last))
		else $error("stalled result changed");

	a_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_set |-> neighbor_count == 4'd0)
		else $error("set pixel with nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> neighbor_count <= 4'd8)
		else $error("neighbour count above eight");

endmodule

bind binary_image_neighbor_count bincnt_checker u_bincnt_checker (.*);

FILE: tb/sv/binary_image_neighbor_count_tb.sv
module binary_image_neighbor_count_tb;
	import bincnt_pkg::*;

	localparam int COLS_MAX      = 32;
	localparam int SETTLE_CYCLES = COLS_MAX + 8;
	localparam int STALL_LIMIT   = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 pixel_bit;
	logic                 out_valid;
	logic                 out_stall;
	logic                 is_set;
	logic [CNT_W-1:0]     neighbor_count;
	logic                 frame_last;

	binary_image_neighbor_count #(
		.MAX_COLS(COLS_MAX)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_bit     (pixel_bit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_set        (is_set),
		.neighbor_count(neighbor_count),
		.frame_last    (frame_last)
	);

	// predictor state
	logic [COL_W-1:0] frame_cols_reg;
	logic [ROW_W-1:0] frame_rows_reg;
	logic             line_bits [3][COLS_MAX];
	int               col_pos;
	int               row_pos;
	int               use_cols;
	int               use_rows;
	res_t             expected_results [$];

	bit tx_idle;
	bit rx_idle;
	int faults;
	int pixels_sent;
	int results_seen;
	int frames_done;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic pixel_at(int r, int c);
		if (r < 0 || c < 0 || r >= use_rows || c >= use_cols)
			return 1'b0;
		return line_bits[r % 3][c];
	endfunction

	function automatic void push_result(int r, int c, logic last);
		res_t e;
		int   n;
		n = 0;
		e.is_set = pixel_at(r, c);
		if (!e.is_set)
			for (int dr = -1; dr <= 1; dr++)
				for (int dc = -1; dc <= 1; dc++)
					if (dr != 0 || dc != 0)
						n += pixel_at(r + dr, c + dc);
		e.count = e.is_set ? '0 : n[CNT_W-1:0];
		e.last  = last;
		expected_results.push_back(e);
	endfunction

	function automatic void predict_pixel(logic b);
		if (col_pos == 0 && row_pos == 0) begin
			use_cols = clamp(int'(frame_cols_reg), 2, COLS_MAX);
			use_rows = clamp(int'(frame_rows_reg), 2, int'(MAX_ROWS));
		end
		line_bits[row_pos % 3][col_pos] = b;
		if (row_pos >= 1 && col_pos >= 1)
			push_result(row_pos - 1, col_pos - 1, 1'b0);
		if (row_pos >= 1 && col_pos == use_cols - 1)
			push_result(row_pos - 1, col_pos, 1'b0);
		if (row_pos == use_rows - 1 && col_pos == use_cols - 1) begin
			for (int x = 0; x < use_cols; x++)
				push_result(row_pos, x, x == use_cols - 1);
			frames_done++;
		end
		col_pos++;
		if (col_pos >= use_cols) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= use_rows)
				row_pos = 0;
		end
	endfunction

	function automatic int frame_pixels();
		return clamp(int'(frame_cols_reg), 2, COLS_MAX) *
			clamp(int'(frame_rows_reg), 2, int'(MAX_ROWS));
	endfunction

	// one request on the pixel channel, optionally pausing until all results are out
	task automatic send_pixel(input logic b, input bit pause);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (pause && gap == 0)
			gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (pause && expected_results.size() != 0)
				@(posedge clk);
		end
		in_valid  <= 1'b1;
		pixel_bit <= b;
		predict_pixel(b);
		pixels_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_bits(input logic [8:0] pattern, input int n);
		for (int i = 0; i < n; i++)
			send_pixel(pattern[i], 1'b0);
	endtask

	task automatic send_random_pixels(input int n, input int pct);
		for (int i = 0; i < n; i++)
			send_pixel($urandom_range(0, 99) < pct, $urandom_range(0, 59) == 0);
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= REG_FRAME_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_write <= 1'b0;
		frame_cols_reg = cols[COL_W-1:0];
		frame_rows_reg = rows;
	endtask

	// sizes below range saturate to 2x2
	task automatic test_smallest_frame();
		write_frame_size(11'd0, 11'd1);
		send_bits(9'b000000111, 4);
		wait_until_drained();
	endtask

	task automatic test_full_neighbourhood();
		write_frame_size(11'd3, 11'd3);
		send_bits(9'b111101111, 9);
		send_bits(9'b000010000, 9);
		wait_until_drained();
	endtask

	// new size written part way through a frame only applies to the next one
	task automatic test_config_mid_frame();
		write_frame_size(11'd4, 11'd3);
		send_random_pixels(6, 50);
		wait_until_drained();
		write_frame_size(11'd5, 11'd2);
		send_random_pixels(6, 50);
		send_random_pixels(10, 50);
		wait_until_drained();
	endtask

	task automatic test_random_frames();
		int                target;
		logic [COL_W-1:0]  cols;
		logic [ROW_W-1:0]  rows;
		target = pixels_sent + 15;
		while (pixels_sent < target) begin
			cols = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(0, 1)) :
				COL_W'($urandom_range(2, 5));
			rows = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom_range(0, 1)) :
				ROW_W'($urandom_range(2, 4));
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			write_frame_size({5'($urandom_range(0, 31)), cols}, rows);
			send_random_pixels(frame_pixels(), $urandom_range(0, 4) * 25);
			wait_until_drained();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// oversized width saturates to the full chain, sent back to back apart from occasional pauses
	task automatic test_widest_frame();
		write_frame_size(11'd63, 11'd2);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_random_pixels(frame_pixels(), 50);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		wait_until_drained();
	endtask

	// result side stalls
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = rx_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: is_set=%0d count=%0d last=%0d",
						is_set, neighbor_count, frame_last);
			end else begin
				e = expected_results.pop_front();
				if (is_set !== e.is_set || neighbor_count !== e.count ||
						frame_last !== e.last) begin
					faults++;
					if (faults <= 10) begin
						$display("result %0d: expected is_set=%0d count=%0d last=%0d",
							results_seen, e.is_set, e.count, e.last);
						$display("    got is_set=%0d count=%0d last=%0d",
							is_set, neighbor_count, frame_last);
					end
				end
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = REG_FRAME_COLS;
		cfg_data       = '0;
		in_valid       = 1'b0;
		pixel_bit      = 1'b0;
		out_stall      = 1'b0;
		tx_idle        = 1'b1;
		rx_idle        = 1'b1;
		faults         = 0;
		pixels_sent    = 0;
		results_seen   = 0;
		frames_done    = 0;
		quiet_cycles   = 0;
		frame_cols_reg = FRAME_COLS_RST;
		frame_rows_reg = FRAME_ROWS_RST;
		col_pos        = 0;
		row_pos        = 0;
		use_cols       = int'(FRAME_COLS_RST);
		use_rows       = int'(FRAME_ROWS_RST);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < COLS_MAX; c++)
				line_bits[r][c] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_smallest_frame();
		test_full_neighbourhood();
		test_config_mid_frame();
		test_random_frames();
		test_widest_frame();

		if (expected_results.size() != 0)
			faults++;
		$display("%0d frames, %0d pixels, %0d results checked; sizes from 2x2 up to 32 columns",
			frames_done, pixels_sent, results_seen);
		$display("included a size change mid-frame, saturated sizes and back to back requests");
		if (faults == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d faults", faults);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
src/bincnt_pkg.sv
src/bincnt_cell.sv
src/bincnt_window.sv
src/bincnt_outq.sv
src/binary_image_neighbor_count.sv
src/bincnt_checker.sv
tb/sv/binary_image_neighbor_count_tb.sv
